>>> rtl/ita_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared codes, request descriptor type and character helpers.
// ----------------------------------------------------------------------------
package ita_pkg;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 4;
    localparam int DIGIT_W = 4;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CMD_W-1:0] CMD_S16 = 3'd0;
    localparam logic [CMD_W-1:0] CMD_U16 = 3'd1;
    localparam logic [CMD_W-1:0] CMD_S32 = 3'd2;
    localparam logic [CMD_W-1:0] CMD_U32 = 3'd3;
    localparam logic [CMD_W-1:0] CMD_HEX = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CHR = 3'd5;

    // Power table index of the first power for each width, and of 10^0
    localparam logic [IDX_W-1:0] IDX_FIRST_32 = 4'd0;
    localparam logic [IDX_W-1:0] IDX_FIRST_16 = 4'd5;
    localparam logic [IDX_W-1:0] IDX_LAST     = 4'd9;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_HEX_A = 8'h37;  // 'A' - 10

    typedef enum logic [1:0] {
        KIND_DEC = 2'd0,
        KIND_HEX = 2'd1,
        KIND_CHR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [IDX_W-1:0]   first;
    } desc_t;

    function automatic logic [VALUE_W-1:0] pow10(input logic [IDX_W-1:0] idx);
        logic [VALUE_W-1:0] p;
        case (idx)
            4'd0:    p = 32'd1000000000;
            4'd1:    p = 32'd100000000;
            4'd2:    p = 32'd10000000;
            4'd3:    p = 32'd1000000;
            4'd4:    p = 32'd100000;
            4'd5:    p = 32'd10000;
            4'd6:    p = 32'd1000;
            4'd7:    p = 32'd100;
            4'd8:    p = 32'd10;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10)
        begin
            c = CHAR_ZERO + {4'b0, nib};
        end
        else
        begin
            c = CHAR_HEX_A + {4'b0, nib};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ita_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter front end
// Classifies each request by format, takes the magnitude of negative values
// and picks the starting power of ten.
// ----------------------------------------------------------------------------
module ita_front (
    input  wire logic [ita_pkg::CMD_W-1:0]   cmd,
    input  wire logic [ita_pkg::VALUE_W-1:0] value,
    input  wire logic                        push,
    output logic                             full,
    output logic                             q_wr,
    output ita_pkg::desc_t                   q_data,
    input  wire logic                        q_full
);
    import ita_pkg::*;

    logic [15:0] low16;
    logic [15:0] neg16;
    logic        known;

    assign low16 = value[15:0];
    assign neg16 = (~low16) + 16'd1;
    assign full  = q_full;

    always_comb
    begin
        known        = 1'b1;
        q_data.kind  = KIND_DEC;
        q_data.neg   = 1'b0;
        q_data.mag   = {16'b0, low16};
        q_data.first = IDX_FIRST_16;
        case (cmd)
            CMD_S16:
            begin
                q_data.neg = low16[15];
                if (low16[15])
                begin
                    q_data.mag = {16'b0, neg16};
                end
            end
            CMD_U16:
            begin
                q_data.mag = {16'b0, low16};
            end
            CMD_S32:
            begin
                q_data.neg   = value[31];
                q_data.mag   = value[31] ? ((~value) + 32'd1) : value;
                q_data.first = IDX_FIRST_32;
            end
            CMD_U32:
            begin
                q_data.mag   = value;
                q_data.first = IDX_FIRST_32;
            end
            CMD_HEX:
            begin
                q_data.kind = KIND_HEX;
            end
            CMD_CHR:
            begin
                q_data.kind = KIND_CHR;
                q_data.mag  = {24'b0, value[7:0]};
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // Drop requests with an unused selector: accept them, queue nothing
    assign q_wr = push && !q_full && known;

endmodule
`default_nettype wire

>>> rtl/ita_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter request queue
// Short first-in first-out buffer between front end and sequencer.
// ----------------------------------------------------------------------------
module ita_queue #(
    parameter int DEPTH = ita_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  ita_pkg::desc_t      wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output ita_pkg::desc_t      rd_data,
    output logic                empty
);
    import ita_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ita_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter sequencer
// Emits the characters of one request at a time, finding decimal digits by
// repeated subtraction of powers of ten, into a one-entry output register.
// ----------------------------------------------------------------------------
module ita_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  ita_pkg::desc_t                  q_data,
    input  wire logic                       q_empty,
    output logic                            q_rd,
    output logic [ita_pkg::CHAR_W-1:0]      ascii_char,
    output logic                            last,
    output logic                            empty,
    input  wire logic                       pop
);
    import ita_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SIGN  = 6'b000010,
        ST_SKIP  = 6'b000100,
        ST_DIGIT = 6'b001000,
        ST_HEX   = 6'b010000,
        ST_CHAR  = 6'b100000
    } state_t;

    state_t             state_reg,  state_next;
    logic [VALUE_W-1:0] mag_reg,    mag_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [DIGIT_W-1:0] digit_reg,  digit_next;
    logic [1:0]         hcnt_reg,   hcnt_next;
    logic               ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]  char_reg,   char_next;
    logic               last_reg,   last_next;

    logic               out_free;
    logic               emit;
    logic [CHAR_W-1:0]  emit_char;
    logic               emit_last;
    logic [VALUE_W-1:0] pow;

    assign out_free   = !ovalid_reg || pop;
    assign pow        = pow10(idx_reg);
    assign ascii_char = char_reg;
    assign last       = last_reg;
    assign empty      = !ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        idx_next   = idx_reg;
        digit_next = digit_reg;
        hcnt_next  = hcnt_reg;
        q_rd       = 1'b0;
        emit       = 1'b0;
        emit_char  = CHAR_ZERO;
        emit_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd       = 1'b1;
                    mag_next   = q_data.mag;
                    idx_next   = q_data.first;
                    digit_next = '0;
                    hcnt_next  = '0;
                    case (q_data.kind)
                        KIND_HEX: state_next = ST_HEX;
                        KIND_CHR: state_next = ST_CHAR;
                        default:  state_next = q_data.neg ? ST_SIGN : ST_SKIP;
                    endcase
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CHAR_MINUS;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (mag_reg == '0)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_char  = CHAR_ZERO;
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg != IDX_LAST && mag_reg < pow)
                begin
                    // advance past leading zeros
                    idx_next = idx_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (mag_reg >= pow)
                begin
                    mag_next   = mag_reg - pow;
                    digit_next = digit_reg + DIGIT_W'(1);
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CHAR_ZERO + {4'b0, digit_reg};
                    emit_last  = (idx_reg == IDX_LAST);
                    digit_next = '0;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_HEX:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_char = hex_char(mag_reg[15:12]);
                    emit_last = (hcnt_reg == 2'd3);
                    mag_next  = {mag_reg[VALUE_W-5:0], 4'b0};
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = mag_reg[CHAR_W-1:0];
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            char_next   = emit_char;
            last_next   = emit_last;
        end
        else if (pop)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        idx_reg   <= idx_next;
        digit_reg <= digit_next;
        hcnt_reg  <= hcnt_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

endmodule
`default_nettype wire

>>> rtl/integer_to_ascii_formatter_core.sv
`default_nettype none
// A request's first character is registered in the output register after the
// request leaves the queue through an idle sequencer, for hex, char, a sign or
// zero; a leading decimal digit also waits for each skipped power and each
// subtraction of its value, and every character waits for a free output register.
// Hex gives four characters, char and zero one; a new request starts only in idle.
// Reset clears the request queue, the sequencer and the output register.
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Front end classifies requests into a short queue; a sequencer turns each
// into ASCII characters, one result per character, with a last marker.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core #(
    parameter int QUEUE_DEPTH = ita_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [ita_pkg::CMD_W-1:0]   cmd,
    input  wire logic [ita_pkg::VALUE_W-1:0] value,
    input  wire logic                        push,
    output logic                             full,
    output logic [ita_pkg::CHAR_W-1:0]       ascii_char,
    output logic                             last,
    output logic                             empty,
    input  wire logic                        pop
);
    import ita_pkg::*;

    desc_t wr_desc;
    desc_t rd_desc;
    logic  q_wr;
    logic  q_full;
    logic  q_rd;
    logic  q_empty;

    ita_front u_front (
        .cmd    (cmd),
        .value  (value),
        .push   (push),
        .full   (full),
        .q_wr   (q_wr),
        .q_data (wr_desc),
        .q_full (q_full)
    );

    ita_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (wr_desc),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (rd_desc),
        .empty   (q_empty)
    );

    ita_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (rd_desc),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .ascii_char (ascii_char),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
`default_nettype wire
